// ===== hdl/pbin_pkg.sv =====
// ----------------------------------------------------------------------------
// pbin_pkg
// Shared widths, codes and types of the 2x2 saturating binning core.
// ----------------------------------------------------------------------------
package pbin_pkg;

  localparam int unsigned PIX_W      = 16;  // pixel and result width
  localparam int unsigned BYTE_W     = 8;   // pixel width in 8-bit mode
  localparam int unsigned SUM_W      = 17;  // horizontal pair sum width
  localparam int unsigned DIM_W      = 13;  // frame size register width
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = DIM_W;

  localparam logic [SUM_W:0] SAT_LIM_8  = (SUM_W+1)'(255);
  localparam logic [SUM_W:0] SAT_LIM_16 = (SUM_W+1)'(65535);

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(1280);
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(960);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_MODE   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // What the current beat does inside the frame.
  typedef struct packed {
    logic pair_first;  // even column: first pixel of a pair
    logic pair_store;  // odd column, even row: write pair sum to line store
    logic pair_emit;   // odd column, odd row: form one binned result
    logic frame_last;  // last used pixel of the frame
  } pos_action_t;

endpackage

// ===== hdl/pbin_pix_if.sv =====
// ----------------------------------------------------------------------------
// pbin_pix_if
// Pixel input channel: valid/ready handshake with one pixel per beat.
// ----------------------------------------------------------------------------
interface pbin_pix_if import pbin_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);

endinterface

// ===== hdl/pbin_bin_if.sv =====
// ----------------------------------------------------------------------------
// pbin_bin_if
// Binned result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
interface pbin_bin_if import pbin_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] binned_value;
  logic             frame_end;

  modport source (output valid, output binned_value, output frame_end, input ready);
  modport sink   (input valid, input binned_value, input frame_end, output ready);

endinterface

// ===== hdl/pbin_pos_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbin_pos_ctrl
// Column and row counters with decode of the action for the current pixel.
// ----------------------------------------------------------------------------
module pbin_pos_ctrl import pbin_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned AddrW      = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [DIM_W-1:0] frame_width_i,
  input  logic [DIM_W-1:0] frame_height_i,
  output pos_action_t      action_o,
  output logic [AddrW-1:0] slot_o
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT);
  localparam int unsigned ColCW = (ColW + 1 > DIM_W) ? ColW + 1 : DIM_W;
  localparam int unsigned RowCW = (RowW + 1 > DIM_W) ? RowW + 1 : DIM_W;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColCW-1:0] w_ext, w_lim, used_w, col_ext, col_inc;
  logic [RowCW-1:0] h_ext, h_lim, used_h, row_ext, row_inc;
  logic             in_frame;

  always_comb begin
    // Sizes above the maximum are taken as the maximum; the low bit is dropped.
    w_ext   = ColCW'(frame_width_i);
    h_ext   = RowCW'(frame_height_i);
    w_lim   = (w_ext > ColCW'(MAX_WIDTH)) ? ColCW'(MAX_WIDTH) : w_ext;
    h_lim   = (h_ext > RowCW'(MAX_HEIGHT)) ? RowCW'(MAX_HEIGHT) : h_ext;
    used_w  = {w_lim[ColCW-1:1], 1'b0};
    used_h  = {h_lim[RowCW-1:1], 1'b0};
    col_ext = ColCW'(col_q);
    row_ext = RowCW'(row_q);
    col_inc = col_ext + ColCW'(1);
    row_inc = row_ext + RowCW'(1);

    in_frame = (col_ext < used_w) && (row_ext < used_h);
    action_o.pair_first = in_frame && !col_q[0];
    action_o.pair_store = in_frame && col_q[0] && !row_q[0];
    action_o.pair_emit  = in_frame && col_q[0] && row_q[0];
    action_o.frame_last = (col_inc == used_w) && (row_inc == used_h);

    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_inc >= w_lim) begin
        col_d = '0;
        row_d = (row_inc >= h_lim) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  assign slot_o = col_q[AddrW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hdl/pbin_line_store.sv =====
// ----------------------------------------------------------------------------
// pbin_line_store
// Single-write, single-read line memory with a registered read port.
// ----------------------------------------------------------------------------
module pbin_line_store import pbin_pkg::*; #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [SUM_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [SUM_W-1:0] rdata_o
);

  logic [SUM_W-1:0] mem [Depth];
  logic [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read, so it stays aligned with a stalled stage.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pbin_out_stage.sv =====
// ----------------------------------------------------------------------------
// pbin_out_stage
// Sum stage aligned with the line store read, saturation and output register.
// ----------------------------------------------------------------------------
module pbin_out_stage import pbin_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [SUM_W-1:0] psum_i,
  input  logic             last_i,
  input  logic             depth_mode_i,
  input  logic [SUM_W-1:0] store_rdata_i,
  output logic             ready_o,
  pbin_bin_if.source       bin_out
);

  logic             a_valid_q, a_valid_d;
  logic [SUM_W-1:0] a_psum_q;
  logic             a_last_q;
  logic             o_valid_q, o_valid_d;
  logic [PIX_W-1:0] o_value_q;
  logic             o_last_q;
  logic             adv_a;
  logic [SUM_W:0]   full_sum;
  logic [SUM_W:0]   lim;
  logic [PIX_W-1:0] sat_sum;

  assign adv_a   = a_valid_q && (!o_valid_q || bin_out.ready);
  assign ready_o = !a_valid_q || !o_valid_q || bin_out.ready;

  always_comb begin
    full_sum = (SUM_W+1)'(store_rdata_i) + (SUM_W+1)'(a_psum_q);
    lim      = depth_mode_i ? SAT_LIM_16 : SAT_LIM_8;
    sat_sum  = (full_sum > lim) ? lim[PIX_W-1:0] : full_sum[PIX_W-1:0];

    a_valid_d = a_valid_q;
    if (take_i) begin
      a_valid_d = 1'b1;
    end else if (adv_a) begin
      a_valid_d = 1'b0;
    end

    o_valid_d = o_valid_q;
    if (adv_a) begin
      o_valid_d = 1'b1;
    end else if (bin_out.ready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      a_psum_q <= psum_i;
      a_last_q <= last_i;
    end
    if (adv_a) begin
      o_value_q <= sat_sum;
      o_last_q  <= a_last_q;
    end
  end

  assign bin_out.valid        = o_valid_q;
  assign bin_out.binned_value = o_value_q;
  assign bin_out.frame_end    = o_last_q;

endmodule

// ===== hdl/pixel_bin_2x2_saturating_core.sv =====
// ----------------------------------------------------------------------------
// pixel_bin_2x2_saturating_core
// 2x2 pixel binning of a raster pixel stream with 8-bit or 16-bit saturation.
// ----------------------------------------------------------------------------
// The core takes one pixel per beat in raster order and sums every 2x2 block
// of pixels into one binned pixel, saturated at 255 in 8-bit mode or at 65535
// in 16-bit mode (in 8-bit mode the upper byte of each pixel is ignored).
// Frame width and height are taken even and clamped to MAX_WIDTH and
// MAX_HEIGHT; a trailing odd column or row is consumed and dropped. The core
// accepts one pixel every clock cycle as long as results are taken; for the
// odd-column pixel that completes a block, the line store read and pair sum
// are registered, then the saturating sum goes into the output register. The
// line store sees at most one write or one read per beat. It is not cleared
// after reset and needs no clearing pass: every entry is written on an even
// row before it is read on the next odd row. The user must write
// configuration only while the core is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module pixel_bin_2x2_saturating_core import pbin_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pbin_pix_if.sink              pix_in,
  pbin_bin_if.source            bin_out
);

  // The line store holds one pair sum for every two columns.
  localparam int unsigned StoreDepth = MAX_WIDTH / 2;
  localparam int unsigned AddrW      = $clog2(StoreDepth);

  // Configuration registers.
  logic             depth_mode_q;
  logic [DIM_W-1:0] frame_width_q;
  logic [DIM_W-1:0] frame_height_q;

  // First pixel of the current horizontal pair.
  logic [PIX_W-1:0] pair_partial_q, pair_partial_d;

  logic             accept;
  logic             stage_ready;
  logic [PIX_W-1:0] pix;
  logic [SUM_W-1:0] pair_sum;
  pos_action_t      action;
  logic [AddrW-1:0] slot;
  logic [SUM_W-1:0] store_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_mode_q   <= 1'b0;
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DEPTH_MODE:   depth_mode_q   <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A beat is taken whenever the sum stage has room, whether or not the
  // pixel will produce a result, so the stream keeps one beat per cycle while the stage has room.
  assign pix_in.ready = stage_ready;
  assign accept       = pix_in.valid && stage_ready;

  // In 8-bit mode only the low byte of the pixel counts.
  assign pix = depth_mode_q ? pix_in.pixel_value
                            : {{(PIX_W-BYTE_W){1'b0}}, pix_in.pixel_value[BYTE_W-1:0]};

  // Horizontal pair sum: stored on even rows, carried to the sum stage on odd rows.
  assign pair_sum = SUM_W'(pair_partial_q) + SUM_W'(pix);

  always_comb begin
    pair_partial_d = pair_partial_q;
    if (accept && action.pair_first) begin
      pair_partial_d = pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_partial_q <= '0;
    end else begin
      pair_partial_q <= pair_partial_d;
    end
  end

  pbin_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AddrW      (AddrW)
  ) u_pos_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (accept),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .action_o       (action),
    .slot_o         (slot)
  );

  // The write on an even row and the read on the following odd row of the
  // same slot are always at least two beats apart, so no bypass is needed.
  pbin_line_store #(
    .Depth (StoreDepth),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && action.pair_store),
    .waddr_i (slot),
    .wdata_i (pair_sum),
    .re_i    (accept && action.pair_emit),
    .raddr_i (slot),
    .rdata_o (store_rdata)
  );

  pbin_out_stage u_out_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (accept && action.pair_emit),
    .psum_i        (pair_sum),
    .last_i        (action.frame_last),
    .depth_mode_i  (depth_mode_q),
    .store_rdata_i (store_rdata),
    .ready_o       (stage_ready),
    .bin_out       (bin_out)
  );

endmodule
